FILE: rtl/rational_arith_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rational arithmetic unit
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define RAU_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RAU_ASSERT(label, clk, rst, prop)
`define RAU_ASSERT_NR(label, clk, prop)
`endif
`endif

FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Opcodes, status codes and widths for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
   localparam int PW = 64;
   typedef enum logic [3:0] {
      OP_MAKE = 4'd0, OP_NEG = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3,
      OP_MUL = 4'd4, OP_DIV = 4'd5, OP_EQ = 4'd6, OP_NE = 4'd7,
      OP_LT = 4'd8, OP_LE = 4'd9
   } op_type;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ZZ = 2'd1;
   localparam logic [1:0] ST_OVF = 2'd2;
   typedef struct packed {
      logic start;
      logic busy;
   } mul_ctl_type;
endpackage

FILE: rtl/rau_mul.sv
// ----------------------------------------------------------------------------
// rau_mul
// Bit-serial 32x32 unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rau_mul
   import rau_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [31:0]       x,
   input  logic [31:0]       y,
   output mul_ctl_type       ctl,
   output logic [PW-1:0]     prod
);
   logic [PW-1:0] acc_ff, acc_in, mc_ff, mc_in;
   logic [31:0]   mp_ff, mp_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;

   always_comb begin
      acc_in = acc_ff; mc_in = mc_ff; mp_in = mp_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         acc_in = '0; mc_in = {32'd0, x}; mp_in = y; cnt_in = 6'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) acc_in = acc_ff + mc_ff;
         mc_in = {mc_ff[PW-2:0], 1'b0};
         mp_in = {1'b0, mp_ff[31:1]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; mc_ff <= mc_in; mp_ff <= mp_in; cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign prod = acc_ff;
endmodule

FILE: rtl/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd, then restoring division of both values by it, bit-serial.
// ----------------------------------------------------------------------------
module rau_gcd
   import rau_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [PW-1:0] n_in,
   input  logic [PW-1:0] d_in,
   output logic          done,
   output logic [PW-1:0] q_num,
   output logic [PW-1:0] q_den
);
   typedef enum logic [2:0] {G_IDLE, G_SHIFT, G_RUN, G_DIVN, G_DIVD, G_DONE} gstate_type;
   gstate_type st_ff;
   logic [PW-1:0] u_ff, v_ff, g_ff, rem_ff, dv_ff, qn_ff, qd_ff;
   logic [6:0] k_ff, cnt_ff;
   logic [PW:0] trial;

   assign trial = {rem_ff, dv_ff[PW-1]} - {1'b0, g_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= G_IDLE;
         done <= 1'b0;
      end else begin
         done <= (st_ff == G_DONE);
         case (st_ff)
            G_IDLE: if (start) begin
               u_ff <= n_in; v_ff <= d_in; qn_ff <= n_in; qd_ff <= d_in;
               k_ff <= '0; st_ff <= G_SHIFT;
            end
            G_SHIFT: begin
               if (!u_ff[0] && !v_ff[0]) begin
                  u_ff <= u_ff >> 1; v_ff <= v_ff >> 1; k_ff <= k_ff + 7'd1;
               end else st_ff <= G_RUN;
            end
            G_RUN: begin
               if (u_ff == '0) begin
                  g_ff <= v_ff << k_ff[5:0];
                  rem_ff <= '0; dv_ff <= qn_ff; cnt_ff <= '0; st_ff <= G_DIVN;
               end else if (!u_ff[0]) u_ff <= u_ff >> 1;
               else if (!v_ff[0]) v_ff <= v_ff >> 1;
               else if (u_ff >= v_ff) u_ff <= (u_ff - v_ff) >> 1;
               else v_ff <= (v_ff - u_ff) >> 1;
            end
            G_DIVN, G_DIVD: begin
               if (cnt_ff == 7'(PW - 1)) begin
                  cnt_ff <= '0; rem_ff <= '0;
                  if (st_ff == G_DIVN) begin
                     qn_ff <= {dv_ff[PW-2:0], !trial[PW]};
                     dv_ff <= qd_ff; st_ff <= G_DIVD;
                  end else begin
                     qd_ff <= {dv_ff[PW-2:0], !trial[PW]};
                     st_ff <= G_DONE;
                  end
               end else begin
                  if (!trial[PW]) begin
                     rem_ff <= trial[PW-1:0]; dv_ff <= {dv_ff[PW-2:0], 1'b1};
                  end else begin
                     rem_ff <= {rem_ff[PW-2:0], dv_ff[PW-1]}; dv_ff <= {dv_ff[PW-2:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
            G_DONE: st_ff <= G_IDLE;
            default: st_ff <= G_IDLE;
         endcase
      end
   end

   assign q_num = qn_ff;
   assign q_den = qd_ff;
endmodule

FILE: rtl/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit
// Fraction arithmetic and compares with gcd reduction, serial datapath.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// req      in   req_tvalid/tready  tdata: op, a_num, a_den, b_num, b_den
// rsp      out  rsp_tvalid/tready  tdata: res_num, res_den, cmp_true, status
// One item at a time. Three serial 32-bit products, then, for arithmetic only,
// a binary gcd on 64-bit values and two 64-bit divisions; compares skip the
// gcd and the divisions.
// Synchronous active-high reset idles the unit. A held result stalls req.
module rational_arith_unit
   import rau_pkg::*;
#(
   parameter int WIDTH = 32
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // op[3:0], a_num, a_den, b_num, b_den, zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata   // res_num[31:0], res_den[62:32], cmp_true, status[65:64]
);
`include "rational_arith_unit_assert.svh"
   typedef enum logic [2:0] {S_IDLE, S_M1, S_M2, S_M3, S_COMB, S_GCD, S_FIN, S_OUT} state_type;
   state_type st_ff;
   op_type op_ff;
   logic signed [31:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [PW-1:0] p1_ff, p2_ff, p3_ff, mn_ff, md_ff;
   logic sn_ff, sd_ff;
   logic [31:0] mx, my;
   logic mstart, gstart, gdone;
   mul_ctl_type mctl;
   logic [PW-1:0] prod, qn, qd;
   logic [71:0] out_ff;
   logic [PW-1:0] lim;
   logic neg;
   logic s1, s2;
   logic signed [PW:0] l1, l2;
   logic sn_in, sd_in, done_in;
   logic [PW-1:0] mn_in, md_in;
   logic [71:0] out_in;

   function automatic logic [31:0] mag(input logic signed [31:0] v);
      mag = v[31] ? 32'(-v) : 32'(v);
   endfunction

   assign lim = (64'd1 << (WIDTH - 1)) - 64'd1;
   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = (st_ff == S_OUT);
   assign rsp_tdata = out_ff;

   // mul uses |an|*|bn| in the second product slot
   always_comb begin
      mx = mag(an_ff); my = mag(bd_ff);
      case (st_ff)
         S_M2: begin mx = mag((op_ff == OP_MUL) ? an_ff : ad_ff); my = mag(bn_ff); end
         S_M3: begin mx = mag(ad_ff); my = mag(bd_ff); end
         default: begin mx = mag(an_ff); my = mag(bd_ff); end
      endcase
   end

   rau_mul u_mul (.clock(clock), .reset(reset), .start(mstart), .x(mx), .y(my),
      .ctl(mctl), .prod(prod));
   rau_gcd u_gcd (.clock(clock), .reset(reset), .start(gstart), .n_in(mn_ff),
      .d_in(md_ff), .done(gdone), .q_num(qn), .q_den(qd));

   logic started_ff;
   assign mstart = (st_ff == S_M1 || st_ff == S_M2 || st_ff == S_M3) && !started_ff;
   assign gstart = (st_ff == S_GCD) && !started_ff && (mn_ff != '0) && (md_ff != '0);
   assign neg = sn_ff != sd_ff;
   assign s1 = (an_ff[31] != bd_ff[31]) && (p1_ff != '0);
   assign s2 = ((ad_ff[31] != bn_ff[31]) ^ (op_ff == OP_SUB)) && (p2_ff != '0);
   assign l1 = s1 ? -$signed({1'b0, p1_ff}) : $signed({1'b0, p1_ff});
   assign l2 = (ad_ff[31] != bn_ff[31]) && (p2_ff != '0) ? -$signed({1'b0, p2_ff})
             : $signed({1'b0, p2_ff});

   always_comb begin
      sn_in = 1'b0; mn_in = '0;
      sd_in = ad_ff[31] != bd_ff[31]; md_in = p3_ff;
      out_in = '0; done_in = 1'b1;
      case (op_ff)
         OP_MAKE, OP_NEG: begin
            sn_in = an_ff[31] ^ (op_ff == OP_NEG);
            mn_in = {32'd0, mag(an_ff)};
            sd_in = ad_ff[31]; md_in = {32'd0, mag(ad_ff)};
            done_in = 1'b0;
         end
         OP_ADD, OP_SUB: begin
            if (s1 == s2) begin sn_in = s1; mn_in = p1_ff + p2_ff; end
            else if (p1_ff >= p2_ff) begin sn_in = s1; mn_in = p1_ff - p2_ff; end
            else begin sn_in = s2; mn_in = p2_ff - p1_ff; end
            done_in = 1'b0;
         end
         OP_MUL: begin
            sn_in = an_ff[31] != bn_ff[31]; mn_in = p2_ff;
            done_in = 1'b0;
         end
         OP_DIV: begin
            sn_in = an_ff[31] != bd_ff[31]; mn_in = p1_ff;
            sd_in = ad_ff[31] != bn_ff[31]; md_in = p2_ff;
            done_in = 1'b0;
         end
         OP_EQ: out_in[63] = (an_ff == bn_ff && ad_ff == bd_ff);
         OP_NE: out_in[63] = (an_ff != bn_ff || ad_ff != bd_ff);
         OP_LT: out_in[63] = (l1 < l2);
         OP_LE: out_in[63] = (l1 <= l2);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         started_ff <= 1'b0;
      end else begin
         case (st_ff)
            S_IDLE: if (req_tvalid) begin
               op_ff <= op_type'(req_tdata[3:0]);
               an_ff <= req_tdata[35:4]; ad_ff <= req_tdata[67:36];
               bn_ff <= req_tdata[99:68]; bd_ff <= req_tdata[131:100];
               started_ff <= 1'b0; st_ff <= S_M1;
            end
            S_M1, S_M2, S_M3: begin
               if (!started_ff) started_ff <= 1'b1;
               else if (!mctl.busy) begin
                  started_ff <= 1'b0;
                  case (st_ff)
                     S_M1: begin p1_ff <= prod; st_ff <= S_M2; end
                     S_M2: begin p2_ff <= prod; st_ff <= S_M3; end
                     default: begin p3_ff <= prod; st_ff <= S_COMB; end
                  endcase
               end
            end
            S_COMB: begin
               sn_ff <= sn_in; mn_ff <= mn_in;
               sd_ff <= sd_in; md_ff <= md_in;
               out_ff <= out_in;
               st_ff <= done_in ? S_OUT : S_GCD;
            end
            S_GCD: begin
               if (mn_ff == '0 || md_ff == '0) begin
                  st_ff <= S_OUT;
                  if (mn_ff == '0 && md_ff == '0) out_ff <= {6'd0, ST_ZZ, 64'd0};
                  else if (md_ff == '0) out_ff <= 72'd1;
                  else out_ff <= 72'd1 << 32;
               end else if (!started_ff) started_ff <= 1'b1;
               else if (gdone) begin
                  started_ff <= 1'b0; st_ff <= S_FIN;
               end
            end
            S_FIN: begin
               st_ff <= S_OUT;
               if (qd > lim || qn > (neg ? lim + 64'd1 : lim))
                  out_ff <= {6'd0, ST_OVF, 64'd0};
               else
                  out_ff <= {6'd0, ST_OK, 1'b0, qd[30:0],
                     neg ? 32'(-qn[31:0]) : qn[31:0]};
            end
            S_OUT: if (rsp_tready) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   `RAU_ASSERT(a_excl, clock, reset, !(req_tready && rsp_tvalid))
   `RAU_ASSERT(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
   `RAU_ASSERT(a_st, clock, reset, rsp_tvalid |-> rsp_tdata[65:64] != 2'd3)
endmodule
